FILE: rtl/assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(name, clk, rst, ante, cons)

`define ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/nps_pkg.sv
package nps_pkg;

  localparam int ROM_SIZE  = 71;
  localparam int ROM_W     = 23;
  localparam int ROM_IDX_W = 7;
  localparam int CMP_W     = 64;

  localparam logic [CMP_W-1:0] SIZE_CAP = 64'd2146435069;

  // prime size ladder, ascending
  localparam logic [ROM_W-1:0] SIZE_ROM [ROM_SIZE] = '{
    23'd3, 23'd7, 23'd17, 23'd23, 23'd29, 23'd37, 23'd47, 23'd59, 23'd71, 23'd89,
    23'd107, 23'd131, 23'd163, 23'd197, 23'd239, 23'd293, 23'd353, 23'd431,
    23'd521, 23'd631, 23'd761, 23'd919, 23'd1103, 23'd1327, 23'd1597, 23'd1931,
    23'd2333, 23'd2801, 23'd3371, 23'd4049, 23'd4861, 23'd5839, 23'd7013,
    23'd8419, 23'd10103, 23'd12143, 23'd14591, 23'd17519, 23'd21023, 23'd25229,
    23'd30293, 23'd36353, 23'd43627, 23'd52361, 23'd62851, 23'd75431, 23'd90523,
    23'd108631, 23'd130363, 23'd156437, 23'd187751, 23'd225307, 23'd270371,
    23'd324449, 23'd389357, 23'd467237, 23'd560689, 23'd672827, 23'd807403,
    23'd968897, 23'd1162687, 23'd1395263, 23'd1674319, 23'd2009191, 23'd2411033,
    23'd2893249, 23'd3471899, 23'd4166287, 23'd4999559, 23'd5999471, 23'd7199369
  };

endpackage

FILE: rtl/next_prime_table_size.sv
`include "assert_macros.svh"

// Hash table size picker. Each word carries a value and an operation (get or
// expand); one result word comes back per input word. An expand whose doubled
// value crosses SIZE_CAP is answered with SIZE_CAP. Values up to the last
// ladder entry are answered by walking the prime ladder ROM one entry per
// cycle. Larger values run a trial-division search on one shared bit-serial
// remainder unit: each odd divisor takes VALUE_WIDTH+1 remainder steps, a
// check and a square test, for each odd candidate tried. The input is not
// ready while an item is being worked on; a finished result waits in the
// output register.
module next_prime_table_size #(
  parameter int VALUE_WIDTH   = 32,
  parameter int TABLE_ENTRIES = 71
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // value
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // operation
  input  logic [0:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // prime
  output logic [((VALUE_WIDTH+8)/8)*8-1:0] m_axis_tdata,
  // not_found
  output logic [0:0] m_axis_tuser
);

  localparam int SW       = VALUE_WIDTH + 1;
  localparam int OUT_W    = ((VALUE_WIDTH + 8) / 8) * 8;
  localparam int CNT_W    = $clog2(SW);
  localparam int ROM_USED = (TABLE_ENTRIES < nps_pkg::ROM_SIZE) ?
                            TABLE_ENTRIES : nps_pkg::ROM_SIZE;
  localparam logic [SW-1:0] SEARCH_MASK = '1;
  localparam logic [nps_pkg::CMP_W-1:0] ROM_LAST =
    nps_pkg::CMP_W'(nps_pkg::SIZE_ROM[ROM_USED-1]);

  typedef enum logic [2:0] {
    S_IDLE, S_ROM, S_CAND, S_TEST, S_DIV, S_CHK, S_DONE
  } state_t;

  state_t                       state;
  logic [SW-1:0]                v;
  logic [nps_pkg::ROM_IDX_W-1:0] idx;
  logic [SW-1:0]                cand;
  logic [SW-1:0]                d;
  logic [SW:0]                  sq;
  logic [SW-1:0]                rem;
  logic [SW-1:0]                dvd;
  logic [CNT_W-1:0]             cnt;
  logic [SW-1:0]                res_prime;
  logic                         res_nf;
  logic [SW-1:0]                prime;
  logic                         not_found;

  logic [VALUE_WIDTH-1:0]       in_value;
  logic                         in_op;
  logic [SW-1:0]                in_dbl;
  logic [SW-1:0]                in_w;
  logic                         in_cap;
  logic [nps_pkg::CMP_W-1:0]    rom_entry;
  logic [SW:0]                  trial;
  logic                         trial_ge;
  logic [SW:0]                  sq_next;

  assign in_value = s_axis_tdata[VALUE_WIDTH-1:0];
  assign in_op    = s_axis_tuser[0];
  assign in_dbl   = {in_value, 1'b0};
  assign in_w     = in_op ? in_dbl : SW'(in_value);
  assign in_cap   = in_op
                  && (nps_pkg::CMP_W'(in_value) < nps_pkg::SIZE_CAP)
                  && (nps_pkg::SIZE_CAP < nps_pkg::CMP_W'(in_dbl));

  assign rom_entry = nps_pkg::CMP_W'(nps_pkg::SIZE_ROM[idx]);

  // shared remainder step: shift in next dividend bit, subtract divisor if it fits
  assign trial    = {rem, dvd[SW-1]};
  assign trial_ge = trial >= {1'b0, d};

  // (d+2)^2 = d^2 + 4d + 4
  assign sq_next = (SW+1)'(sq + {d, 2'b00} + (SW+2)'(4));

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = OUT_W'(prime);
  assign m_axis_tuser  = not_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            v   <= in_w;
            idx <= '0;
            if (in_cap) begin
              res_prime <= nps_pkg::SIZE_CAP[SW-1:0];
              res_nf    <= 1'b0;
              state     <= S_DONE;
            end else if (nps_pkg::CMP_W'(in_w) <= ROM_LAST) begin
              state <= S_ROM;
            end else begin
              cand  <= in_w | SW'(1);
              state <= S_CAND;
            end
          end
        end
        S_ROM: begin
          if (rom_entry >= nps_pkg::CMP_W'(v)) begin
            res_prime <= rom_entry[SW-1:0];
            res_nf    <= 1'b0;
            state     <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_CAND: begin
          if (cand == SEARCH_MASK) begin
            res_prime <= '0;
            res_nf    <= 1'b1;
            state     <= S_DONE;
          end else begin
            d     <= SW'(3);
            sq    <= (SW+1)'(9);
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (sq > {1'b0, cand}) begin
            res_prime <= cand;
            res_nf    <= 1'b0;
            state     <= S_DONE;
          end else begin
            rem   <= '0;
            dvd   <= cand;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= trial_ge ? SW'(trial - {1'b0, d}) : trial[SW-1:0];
          dvd <= {dvd[SW-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(SW - 1)) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (rem == '0) begin
            cand  <= cand + SW'(2);
            state <= S_CAND;
          end else begin
            d     <= d + SW'(2);
            sq    <= sq_next;
            state <= S_TEST;
          end
        end
        S_DONE: begin
          // load the output register once the previous word has left
          if (!m_axis_tvalid || m_axis_tready) begin
            prime         <= res_prime;
            not_found     <= res_nf;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMP(a_div_odd, clk, rst, state == S_DIV, d[0] && d >= SW'(3))
  `ASSERT_IMP(a_rem_lt_d, clk, rst, state == S_DIV || state == S_CHK, rem < d)
  `ASSERT_IMP(a_cand_odd, clk, rst, state == S_TEST || state == S_CHK, cand[0])
  `ASSERT_IMP(a_nf_zero, clk, rst, m_axis_tvalid && m_axis_tuser[0], prime == '0)
  `ASSERT_NXT(a_busy, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule
